// ----- design/assert_macros.svh -----
// Assertion macros shared by the allocator RTL.
// Relies on the including module having signals named clock and reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds on every clock edge outside reset
`define ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Check that a trigger implies a consequence in the same cycle
`define ASSERT_IMPLY(label, trig, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |-> (cons)) \
      else $error(msg);

// Check that a trigger implies a consequence in the next cycle
`define ASSERT_NEXT(label, trig, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/ilffa_pkg.sv -----
// Package for the implicit-list first-fit allocator: sizes, widths, payload types.
// No dependencies; imported by the allocator top level.
package ilffa_pkg;

   // Heap geometry
   localparam int HEAP_GRANULES = 4096;
   localparam int GRANULE_BYTES = 8;
   localparam int ADDR_W        = $clog2(HEAP_GRANULES);
   localparam int GRAN_SHIFT    = $clog2(GRANULE_BYTES);

   // Byte offsets and sums of two headers fit in this width
   localparam int OFF_W = 17;
   localparam int HDR_W = 16;

   localparam logic [OFF_W-1:0] HEAP_CAP = OFF_W'(HEAP_GRANULES * GRANULE_BYTES);
   localparam logic [OFF_W-1:0] GRAN_MASK = ~OFF_W'(GRANULE_BYTES - 1);
   localparam logic [OFF_W-1:0] HDR_BYTES = OFF_W'(GRANULE_BYTES);

   // Bound on header visits in one walk
   localparam int WALK_STEP_LIMIT = 4 * HEAP_GRANULES + 4;
   localparam int GUARD_W         = $clog2(WALK_STEP_LIMIT + 1);
   localparam logic [GUARD_W-1:0] GUARD_MAX = GUARD_W'(WALK_STEP_LIMIT);

   localparam logic [15:0] HEAP_BYTES_RESET = 16'd32768;

   // Request modes and result codes
   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;
   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FAIL = 1'b1;

   typedef struct packed {
      logic        mode;
      logic [15:0] request_bytes;
      logic [14:0] release_offset;
   } req_type;

   typedef struct packed {
      logic        status;
      logic [14:0] payload_offset;
   } rsp_type;

endpackage

// ----- design/implicit_list_first_fit_allocator.sv -----
// Implicit-list first-fit heap allocator: header memory, walk sequencer, break register.
// Depends on ilffa_pkg and assert_macros.svh.
//
// Usage
//   Request channel: drive req_payload and raise start while busy is low; the
//   transfer happens at that clock edge. mode 0 allocates request_bytes of
//   payload, mode 1 frees the block whose payload starts at release_offset.
//   Result channel: rsp_strobe is high for exactly one cycle with rsp_payload
//   (status, payload_offset). The receiver cannot stall, so every result must
//   be taken in the cycle it appears. busy is low again in that same cycle.
//   Configuration: csr_wr_en with csr_wr_data writes heap_bytes; write only
//   while the block is idle.
// Sequencing (one request at a time)
//   Zero or oversize allocate, and an ignored free: result registered at the transfer.
//   Valid free: read the header, then write it back with the result.
//   Allocate: a fetch and a test state per header visited in the walk, a successor
//   read when a small free block has a successor below the break (on a merge the
//   merged header is visited again), then split and mark, or extend the break.
//   The header memory's registered read sets this pace.
// Reset
//   Synchronous reset clears the break to zero and heap_bytes to 32768. The
//   header memory is not cleared; only headers below the break are ever read.
`include "assert_macros.svh"

module implicit_list_first_fit_allocator (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  ilffa_pkg::req_type   req_payload,
   output logic                 rsp_strobe,
   output ilffa_pkg::rsp_type   rsp_payload,
   input  logic                 csr_wr_en,
   input  logic [15:0]          csr_wr_data
);
   import ilffa_pkg::*;

   // Sequencer states
   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_FREE_WR   = 3'd1;
   localparam logic [2:0] ST_WALK_TOP  = 3'd2;
   localparam logic [2:0] ST_WALK_HDR  = 3'd3;
   localparam logic [2:0] ST_WALK_NEXT = 3'd4;
   localparam logic [2:0] ST_FIT_SPLIT = 3'd5;
   localparam logic [2:0] ST_FIT_MARK  = 3'd6;
   localparam logic [2:0] ST_EXTEND    = 3'd7;

   logic [2:0]         state_ff, state_in;
   logic [OFF_W-1:0]   hdr_off_ff, hdr_off_in;
   logic [OFF_W-1:0]   need_ff, need_in;
   logic [HDR_W-1:0]   size_ff, size_in;
   logic [GUARD_W-1:0] guard_ff, guard_in;
   logic [15:0]        break_ff, break_in;
   logic [15:0]        heap_bytes_ff;
   logic               rsp_strobe_ff, rsp_strobe_in;
   rsp_type            rsp_payload_ff, rsp_payload_in;

   // Header memory
   logic [HDR_W-1:0]   hdr_mem [HEAP_GRANULES];
   logic [HDR_W-1:0]   rd_data_ff;
   logic               rd_en;
   logic [OFF_W-1:0]   rd_off;
   logic               wr_req;
   logic               wr_en;
   logic [OFF_W-1:0]   wr_off;
   logic [HDR_W-1:0]   wr_data;

   // Derived values
   logic               accept;
   logic [OFF_W-1:0]   break_ext;
   logic [OFF_W-1:0]   heap_ext;
   logic [OFF_W-1:0]   limit;
   logic [OFF_W-1:0]   req_ext;
   logic [OFF_W-1:0]   rel_hdr;
   logic               free_ok;
   logic [OFF_W-1:0]   need_req;
   logic [OFF_W-1:0]   rd_ext;
   logic [OFF_W-1:0]   next_off;
   logic [HDR_W-1:0]   merged;
   logic [OFF_W-1:0]   split_off;
   logic [OFF_W-1:0]   room;

   assign accept    = start && !busy;
   assign busy      = (state_ff != ST_IDLE);
   assign break_ext = {1'b0, break_ff};
   assign heap_ext  = {1'b0, heap_bytes_ff};
   assign limit     = ((heap_ext < HEAP_CAP) ? heap_ext : HEAP_CAP) & GRAN_MASK;
   assign req_ext   = {1'b0, req_payload.request_bytes};
   assign rel_hdr   = {2'b00, req_payload.release_offset} - HDR_BYTES;
   assign free_ok   = ({2'b00, req_payload.release_offset} >= HDR_BYTES)
                   && (req_payload.release_offset[GRAN_SHIFT-1:0] == '0)
                   && (rel_hdr < break_ext);
   assign need_req  = (req_ext + HDR_BYTES + OFF_W'(GRANULE_BYTES - 1)) & GRAN_MASK;
   assign rd_ext    = {1'b0, rd_data_ff};
   assign next_off  = hdr_off_ff + rd_ext;
   assign merged    = size_ff + rd_data_ff;
   assign split_off = hdr_off_ff + need_ff;
   assign room      = limit - break_ext;

   // Drop writes that fall beyond the last granule
   assign wr_en = wr_req && (wr_off < HEAP_CAP);

   // Sequence one request through the header memory
   always_comb begin
      state_in       = state_ff;
      hdr_off_in     = hdr_off_ff;
      need_in        = need_ff;
      size_in        = size_ff;
      guard_in       = guard_ff;
      break_in       = break_ff;
      rsp_strobe_in  = 1'b0;
      rsp_payload_in = rsp_payload_ff;
      rd_en          = 1'b0;
      rd_off         = hdr_off_ff;
      wr_req         = 1'b0;
      wr_off         = hdr_off_ff;
      wr_data        = rd_data_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_payload.mode == MODE_FREE) begin
                  if (free_ok) begin
                     rd_en      = 1'b1;
                     rd_off     = rel_hdr;
                     hdr_off_in = rel_hdr;
                     state_in   = ST_FREE_WR;
                  end else begin
                     rsp_strobe_in  = 1'b1;
                     rsp_payload_in = '{status: STATUS_OK, payload_offset: '0};
                  end
               end else if ((req_ext == '0) || (req_ext > limit)) begin
                  rsp_strobe_in  = 1'b1;
                  rsp_payload_in = '{status: STATUS_FAIL, payload_offset: '0};
               end else begin
                  need_in    = need_req;
                  hdr_off_in = '0;
                  guard_in   = '0;
                  state_in   = ST_WALK_TOP;
               end
            end
         end

         // Clear the allocated bit of the freed header
         ST_FREE_WR: begin
            wr_req         = 1'b1;
            wr_data        = {rd_data_ff[HDR_W-1:1], 1'b0};
            rsp_strobe_in  = 1'b1;
            rsp_payload_in = '{status: STATUS_OK, payload_offset: '0};
            state_in       = ST_IDLE;
         end

         // Fetch the next header while below the break and within the walk guard
         ST_WALK_TOP: begin
            if ((hdr_off_ff < break_ext) && (guard_ff < GUARD_MAX)) begin
               rd_en    = 1'b1;
               guard_in = guard_ff + 1'b1;
               state_in = ST_WALK_HDR;
            end else begin
               state_in = ST_EXTEND;
            end
         end

         // Test the header for a fit, a merge candidate, a step or a zero-size end
         ST_WALK_HDR: begin
            size_in = rd_data_ff;
            if (!rd_data_ff[0] && (rd_ext >= need_ff)) begin
               state_in = ST_FIT_SPLIT;
            end else if (!rd_data_ff[0] && (rd_data_ff != '0) && (next_off < break_ext)) begin
               rd_en    = 1'b1;
               rd_off   = next_off;
               state_in = ST_WALK_NEXT;
            end else if (rd_data_ff[HDR_W-1:1] == '0) begin
               state_in = ST_EXTEND;
            end else begin
               hdr_off_in = hdr_off_ff + {1'b0, rd_data_ff[HDR_W-1:1], 1'b0};
               state_in   = ST_WALK_TOP;
            end
         end

         // Merge with a following free block, else advance past this one
         ST_WALK_NEXT: begin
            if (!rd_data_ff[0] && (rd_data_ff != '0)) begin
               wr_req  = 1'b1;
               wr_data = merged;
            end else begin
               hdr_off_in = hdr_off_ff + {1'b0, size_ff};
            end
            state_in = ST_WALK_TOP;
         end

         // Split off the remainder as a free block
         ST_FIT_SPLIT: begin
            if (need_ff < {1'b0, size_ff}) begin
               wr_req  = 1'b1;
               wr_off  = split_off;
               wr_data = size_ff - need_ff[HDR_W-1:0];
            end
            state_in = ST_FIT_MARK;
         end

         // Mark the fitted block allocated
         ST_FIT_MARK: begin
            wr_req         = 1'b1;
            wr_data        = {need_ff[HDR_W-1:1], 1'b1};
            rsp_strobe_in  = 1'b1;
            rsp_payload_in = '{status: STATUS_OK,
                               payload_offset: hdr_off_ff[14:0] + HDR_BYTES[14:0]};
            state_in       = ST_IDLE;
         end

         // Grow the break, or fail on overflow
         ST_EXTEND: begin
            rsp_strobe_in = 1'b1;
            state_in      = ST_IDLE;
            if ((break_ext > limit) || (room < need_ff)) begin
               rsp_payload_in = '{status: STATUS_FAIL, payload_offset: '0};
            end else begin
               wr_req         = 1'b1;
               wr_off         = break_ext;
               wr_data        = {need_ff[HDR_W-1:1], 1'b1};
               break_in       = break_ff + need_ff[15:0];
               rsp_payload_in = '{status: STATUS_OK,
                                  payload_offset: break_ff[14:0] + HDR_BYTES[14:0]};
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         break_ff      <= '0;
         heap_bytes_ff <= HEAP_BYTES_RESET;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         break_ff      <= break_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_wr_en) begin
            heap_bytes_ff <= csr_wr_data;
         end
      end
   end

   // Walk context and result payload
   always_ff @(posedge clock) begin
      hdr_off_ff     <= hdr_off_in;
      need_ff        <= need_in;
      size_ff        <= size_in;
      guard_ff       <= guard_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   // Header memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         hdr_mem[wr_off[ADDR_W+GRAN_SHIFT-1:GRAN_SHIFT]] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= hdr_mem[rd_off[ADDR_W+GRAN_SHIFT-1:GRAN_SHIFT]];
      end
   end

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_payload_ff;

   `ASSERT_IMPLY(a_rsp_when_idle, rsp_strobe, !busy, "result strobe while sequencer busy")
   `ASSERT_NEXT(a_accept_progress, accept, rsp_strobe || busy, "accepted request dropped")
   `ASSERT_ALWAYS(a_break_in_heap, break_ext <= HEAP_CAP, "break beyond heap capacity")
   `ASSERT_IMPLY(a_no_idle_write, wr_req, state_ff != ST_IDLE, "header write while idle")

endmodule

// ----- dv/implicit_list_first_fit_allocator_tb.sv -----
// Testbench for the implicit-list first-fit allocator: directed and random allocate/free
// traffic, responses checked against a heap predictor kept inside the bench.
// Depends on ilffa_pkg and the implicit_list_first_fit_allocator RTL.
module implicit_list_first_fit_allocator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ilffa_pkg::*;

   localparam int PERIOD           = 10;
   localparam int WATCHDOG_NS      = 500_000_000;
   localparam int SHOWN_MISMATCHES = 10;
   localparam int CAP_BYTES        = HEAP_GRANULES * GRANULE_BYTES;
   // two copies of the heap: one runs ahead to shape stimulus, one follows transfers
   localparam int PLAN  = 0;
   localparam int CHECK = 1;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        start       = 1'b0;
   logic        busy;
   req_type     req_payload = '0;
   logic        rsp_strobe;
   rsp_type     rsp_payload;
   logic        csr_wr_en   = 1'b0;
   logic [15:0] csr_wr_data = '0;

   // heap predictor state
   logic [15:0] hdr [2][HEAP_GRANULES];
   bit          touched [2][HEAP_GRANULES];
   int          brk [2];
   int          heap_size [2];

   req_type request_fifo [$];
   rsp_type grant_fifo [$];
   int      fault_count = 0;
   int      gap_left    = 0;
   bit      no_idle     = 1'b0;

   implicit_list_first_fit_allocator uut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #(PERIOD / 2) clock = ~clock;

   function automatic int heap_limit(input int k);
      int lim;
      lim = (heap_size[k] < CAP_BYTES) ? heap_size[k] : CAP_BYTES;
      return lim & ~7;
   endfunction

   function automatic void put_header(input int k, input int off, input int v);
      hdr[k][off / GRANULE_BYTES]     = 16'(v);
      touched[k][off / GRANULE_BYTES] = 1'b1;
   endfunction

   // Apply one request to heap copy k and return the response it earns
   function automatic rsp_type alloc_step(input int k, input req_type it);
      rsp_type r;
      int      lim, need, h, s, t, rel, steps;
      bit      hit, stop, merged;
      r = '0;
      r.status = STATUS_OK;
      lim = heap_limit(k);

      // release: clear the allocated flag, drop bad offsets silently
      if (it.mode == MODE_FREE) begin
         rel = it.release_offset;
         if (rel >= 8 && rel % 8 == 0 && rel - 8 < brk[k])
            put_header(k, rel - 8, hdr[k][(rel - 8) / GRANULE_BYTES] & ~16'd1);
         return r;
      end

      if (it.request_bytes == 0 || it.request_bytes > lim) begin
         r.status = STATUS_FAIL;
         return r;
      end
      need = (it.request_bytes + 15) & ~7;

      // first-fit walk, coalescing a free block with a free successor on the way
      h = 0;
      steps = 0;
      hit = 1'b0;
      stop = 1'b0;
      while (!hit && !stop && h < brk[k] && steps < WALK_STEP_LIMIT) begin
         s = hdr[k][h / GRANULE_BYTES];
         steps++;
         merged = 1'b0;
         if (s % 2 == 0) begin
            if (s >= need) begin
               hit = 1'b1;
            end else if (s != 0 && h + s < brk[k]) begin
               t = hdr[k][(h + s) / GRANULE_BYTES];
               // merge and look at the same header again
               if (t % 2 == 0 && t != 0) begin
                  put_header(k, h, s + t);
                  merged = 1'b1;
               end
            end
         end
         if (!hit && !merged) begin
            if ((s & ~1) == 0) stop = 1'b1;
            else h += s & ~1;
         end
      end

      // split off the remainder, or grow the break when nothing fits
      if (hit) begin
         s = hdr[k][h / GRANULE_BYTES];
         if (need < s) put_header(k, h + need, s - need);
      end else begin
         if (brk[k] > lim || lim - brk[k] < need) begin
            r.status = STATUS_FAIL;
            return r;
         end
         h = brk[k];
         brk[k] = (brk[k] + need) & 16'hFFFF;
      end
      put_header(k, h, need | 1);
      r.payload_offset = 15'(h + 8);
      return r;
   endfunction

   // A release below the break must land on a granule that has held a header
   function automatic bit free_ok(input int rel);
      if (rel >= 8 && rel % 8 == 0 && rel - 8 < brk[PLAN])
         return touched[PLAN][(rel - 8) / GRANULE_BYTES];
      return 1'b1;
   endfunction

   // Payload offset of a random block in the planned heap, -1 when none qualifies
   function automatic int pick_block(input bit used_only);
      int h, s, n, pick, seen;
      n = 0;
      pick = 0;
      for (int pass = 0; pass < 2; pass++) begin
         if (pass == 1) begin
            if (n == 0) return -1;
            pick = $urandom_range(0, n - 1);
         end
         h = 0;
         seen = 0;
         while (h < brk[PLAN]) begin
            s = hdr[PLAN][h / GRANULE_BYTES];
            if (s % 2 == 1 || !used_only) begin
               if (pass == 1 && seen == pick) return h + 8;
               seen++;
            end
            h = ((s & ~1) == 0) ? brk[PLAN] : h + (s & ~1);
         end
         n = seen;
      end
      return -1;
   endfunction

   function automatic int pick_size(input int lim);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 4) return 0;
      if (roll < 8) return $urandom_range(lim + 1, 65535);
      if (roll < 20) return $urandom_range(1, lim);
      return $urandom_range(1, (lim >= 32) ? lim / 16 : 2);
   endfunction

   function automatic int pick_gap();
      int roll;
      // switch now and then between idling and back-to-back transfers
      if ($urandom_range(0, 39) == 0) no_idle = !no_idle;
      if (no_idle) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 95) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   task automatic push_alloc(input int n);
      req_type it;
      it.mode           = MODE_ALLOC;
      it.request_bytes  = 16'(n);
      it.release_offset = 15'($urandom_range(0, 32767));
      void'(alloc_step(PLAN, it));
      request_fifo.push_back(it);
   endtask

   task automatic push_free(input int rel);
      req_type it;
      if (!free_ok(rel)) return;
      it.mode           = MODE_FREE;
      it.request_bytes  = 16'($urandom_range(0, 65535));
      it.release_offset = 15'(rel);
      void'(alloc_step(PLAN, it));
      request_fifo.push_back(it);
   endtask

   // Hold until every queued request has been transferred and answered
   task automatic wait_drained();
      do @(negedge clock);
      while (request_fifo.size() != 0 || grant_fifo.size() != 0 || start || busy);
   endtask

   task automatic write_heap(input int bytes);
      wait_drained();
      repeat (4) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= 16'(bytes);
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      heap_size[PLAN]  = bytes;
      heap_size[CHECK] = bytes;
   endtask

   // Mostly live-block releases and sized allocations, some stale and junk releases
   task automatic random_phase(input int count);
      int roll, off;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 59) == 0) wait_drained();
         roll = $urandom_range(0, 99);
         off = -1;
         if (roll >= 55 && roll < 82) off = pick_block(1'b1);
         else if (roll >= 82 && roll < 90) off = pick_block(1'b0);
         if (roll >= 90) begin
            off = $urandom_range(0, 32767);
            if (!free_ok(off)) off = off | 1;
         end
         if (off < 0) push_alloc(pick_size(heap_limit(PLAN)));
         else push_free(off);
      end
   endtask

   task automatic flag_fault(input string what, input rsp_type want, input rsp_type got);
      fault_count++;
      if (fault_count <= SHOWN_MISMATCHES)
         $display("%0t: %s: expected status %0d offset %0d, got status %0d offset %0d",
                  $time, what, want.status, want.payload_offset,
                  got.status, got.payload_offset);
   endtask

   // Request driver: present the head of the queue, hold it while busy
   always @(posedge clock) begin : drive_requests
      if (reset) begin
         start    <= 1'b0;
         gap_left = 0;
      end else begin
         if (start && !busy) begin
            void'(request_fifo.pop_front());
            gap_left = pick_gap();
         end
         if (start && busy) begin
            // hold the current request
         end else if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (request_fifo.size() != 0) begin
            start       <= 1'b1;
            req_payload <= request_fifo[0];
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Response monitor: check each strobe, then predict for a new transfer
   always @(posedge clock) begin : check_replies
      rsp_type want;
      if (!reset) begin
         if (rsp_strobe) begin
            if (grant_fifo.size() == 0) begin
               flag_fault("unexpected response", '0, rsp_payload);
            end else begin
               want = grant_fifo.pop_front();
               if (rsp_payload.status !== want.status)
                  flag_fault("status mismatch", want, rsp_payload);
               else if (rsp_payload.payload_offset !== want.payload_offset)
                  flag_fault("offset mismatch", want, rsp_payload);
            end
         end
         if (start && !busy) grant_fifo.push_back(alloc_step(CHECK, req_payload));
      end
   end

   initial begin : stimulus
      for (int k = 0; k < 2; k++) begin
         brk[k] = 0;
         heap_size[k] = HEAP_BYTES_RESET;
         for (int g = 0; g < HEAP_GRANULES; g++) begin
            hdr[k][g] = '0;
            touched[k][g] = 1'b0;
         end
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // smallest heap: one block fits, zero and oversize sizes, junk releases, reuse
      write_heap(16);
      push_alloc(0);
      push_alloc(1);
      push_alloc(8);
      push_alloc(17);
      push_alloc(65535);
      push_free(0);
      push_free(4);
      push_free(12);
      push_free(24);
      push_free(8);
      push_free(8);
      push_alloc(8);

      // unaligned heap size: coalesce and split, exact reuse, merge kept on failure
      write_heap(1001);
      push_alloc(24);
      push_alloc(24);
      push_alloc(24);
      push_free(56);
      push_free(88);
      push_alloc(40);
      push_free(24);
      push_alloc(20);
      push_free(56);
      push_alloc(992);
      push_alloc(32768);
      push_free(32767);
      push_free(32760);
      random_phase(170);

      write_heap(4096);
      random_phase(170);

      // heap shrunk below the break
      write_heap(100);
      random_phase(120);

      write_heap(32768);
      push_alloc(32768);
      push_alloc(32760);
      random_phase(200);

      write_heap(2047);
      random_phase(160);

      wait_drained();
      repeat (20) @(posedge clock);
      if (fault_count == 0) begin
         $display("[implicit_list_first_fit_allocator] OK");
      end else begin
         $display("[implicit_list_first_fit_allocator] ERROR");
      end
      $finish;
   end

   initial begin : watchdog
      #WATCHDOG_NS;
      $display("[implicit_list_first_fit_allocator] ERROR");
      $finish;
   end

endmodule
